### hdl/rcc_pkg.sv
// Package: shared constants, codes and types of the read coverage classifier.
`timescale 1ns / 1ps
package rcc_pkg;

  // Default saturation limit of the per-read counters
  localparam int unsigned MAX_READ_LEN_DEF = 1048575;

  // Field widths
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STAT_W   = 24;
  localparam int unsigned TARGET_W = 16;
  localparam int unsigned CLASS_W  = 2;

  // Coverage target after reset, and the cap on the low threshold
  localparam logic [TARGET_W-1:0] COV_TARGET_RST = 16'd100;
  localparam logic [5:0]          LOW_THR_CAP    = 6'd50;

  // Coverage class codes
  typedef enum logic [CLASS_W-1:0] {
    COV_LOW  = 2'd0,
    COV_OK   = 2'd1,
    COV_HIGH = 2'd2
  } cov_class_e;

  // Divergence class codes
  typedef enum logic [CLASS_W-1:0] {
    DIV_UNIFORM = 2'd0,
    DIV_OK      = 2'd1,
    DIV_HIGH    = 2'd2
  } div_class_e;

endpackage

### hdl/rcc_in_if.sv
// Interface: input channel carrying one k-mer count with the read statistics.
`timescale 1ns / 1ps
interface rcc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] kmer_count;
  logic [23:0] read_mean;
  logic [23:0] read_std;
  logic        last_item;

  modport source (output valid, kmer_count, read_mean, read_std, last_item, input ready);
  modport sink   (input valid, kmer_count, read_mean, read_std, last_item, output ready);
endinterface

### hdl/rcc_out_if.sv
// Interface: result channel carrying the classification of one read.
`timescale 1ns / 1ps
interface rcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] coverage_class;
  logic       long_low_run;
  logic [1:0] divergence_class;

  modport source (output valid, coverage_class, long_low_run, divergence_class, input ready);
  modport sink   (input valid, coverage_class, long_low_run, divergence_class, output ready);
endinterface

### hdl/read_coverage_classifier.sv
// Top level: read coverage classifier, per-read run tracking and result register.
`timescale 1ns / 1ps
// Usage
//   in_i  : one transfer per read position: k-mer count, read mean and std
//           (unsigned Q16.8) and last_item marking the final position.
//   out_o : one transfer per read, issued for the item marked last: coverage
//           class, long-low-run flag and divergence class.
//   cfg_we_i / cfg_wdata_i : write of the coverage target, only while idle.
// Timing
//   An accepted item is held in the input register; when it advances it
//   updates the run counters and, for a last item, loads the output
//   register, from which the result is presented on out_o.
//   Throughput is one item per cycle unless a last item waits for out_o,
//   set by the single input register and the single result register.
// Reset
//   Counters clear, both registers empty, coverage target returns to 100.
// Stall
//   While a result waits, non-last items keep flowing; a further last item
//   holds in the input register and in_i.ready drops until out_o is taken.
module read_coverage_classifier #(
  parameter int unsigned MAX_READ_LEN = rcc_pkg::MAX_READ_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  rcc_in_if.sink            in_i,
  rcc_out_if.source         out_o
);
  import rcc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_READ_LEN + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_READ_LEN);

  // Configuration register
  logic [TARGET_W-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= COV_TARGET_RST;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Input register
  logic               s1_valid_q;
  logic [COUNT_W-1:0] s1_count_q;
  logic [STAT_W-1:0]  s1_mean_q;
  logic [STAT_W-1:0]  s1_std_q;
  logic               s1_last_q;
  logic               s1_adv;
  logic               out_free;
  logic               out_valid_q;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready  = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_count_q <= in_i.kmer_count;
      s1_mean_q  <= in_i.read_mean;
      s1_std_q   <= in_i.read_std;
      s1_last_q  <= in_i.last_item;
    end
  end

  // Thresholds and ratio tests by cross-multiplication
  logic [14:0]   half_target;
  logic [5:0]    low_thr;
  logic          prevalent;
  logic [27:0]   count_x2560;
  logic [27:0]   mean_x3;
  logic          is_low;
  logic          is_break;

  assign half_target = target_q[TARGET_W-1:1];
  assign low_thr     = (half_target > 15'(LOW_THR_CAP)) ? LOW_THR_CAP : half_target[5:0];
  assign prevalent   = s1_mean_q >= {10'd0, low_thr, 8'd0};
  assign count_x2560 = {12'd0, s1_count_q} * 28'd2560;
  assign mean_x3     = {4'd0, s1_mean_q} * 28'd3;
  assign is_low      = (s1_count_q <= 16'd1) || (count_x2560 <= {4'd0, s1_mean_q});
  assign is_break    = (s1_count_q > 16'd1) && (count_x2560 > mean_x3);

  // Run counters
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] longest_q, longest_d;
  logic [CW-1:0] items_q, items_d;
  logic [CW-1:0] items_inc;
  logic [CW-1:0] run_inc;

  assign items_inc = (items_q >= CNT_MAX) ? CNT_MAX : items_q + 1'b1;
  assign run_inc   = (run_q >= CNT_MAX) ? CNT_MAX : run_q + 1'b1;

  always_comb begin
    run_d     = run_q;
    longest_d = longest_q;
    items_d   = items_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        run_d     = '0;
        longest_d = '0;
        items_d   = '0;
      end else begin
        items_d = items_inc;
        if (prevalent) begin
          priority if (is_low) begin
            run_d = run_inc;
          end else if (is_break) begin
            if (run_q > longest_q) begin
              longest_d = run_q;
            end
            run_d = '0;
          end else begin
            // count between the two bounds: run left as it is
            run_d = run_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      longest_q <= '0;
      items_q   <= '0;
    end else begin
      run_q     <= run_d;
      longest_q <= longest_d;
      items_q   <= items_d;
    end
  end

  // Result of the read
  logic [CW+3:0] longest_x10;
  logic [CW+3:0] items_x3;
  logic [30:0]   std_x100;
  logic [30:0]   mean_x8;
  logic [26:0]   std_x5;
  logic          mean_nz;
  cov_class_e    cov_d;
  div_class_e    div_d;
  logic          longlow_d;

  assign longest_x10 = {4'd0, longest_q} * (CW + 4)'(10);
  assign items_x3    = {4'd0, items_inc} * (CW + 4)'(3);
  assign std_x100    = {7'd0, s1_std_q} * 31'd100;
  assign mean_x8     = {4'd0, s1_mean_q, 3'd0};
  assign std_x5      = {3'd0, s1_std_q} * 27'd5;
  assign mean_nz     = s1_mean_q != '0;
  assign longlow_d   = prevalent && (longest_x10 > items_x3);

  always_comb begin
    priority if (!prevalent) begin
      cov_d = COV_LOW;
    end else if (s1_mean_q < {target_q, 8'd0}) begin
      cov_d = COV_OK;
    end else begin
      cov_d = COV_HIGH;
    end
  end

  always_comb begin
    priority if ((mean_nz && (std_x100 < mean_x8)) || (s1_std_q < 24'd5120)) begin
      div_d = DIV_UNIFORM;
    end else if (mean_nz && (std_x5 < {3'd0, s1_mean_q})) begin
      div_d = DIV_OK;
    end else begin
      div_d = DIV_HIGH;
    end
  end

  // Output register
  logic [CLASS_W-1:0] cov_q;
  logic               longlow_q;
  logic [CLASS_W-1:0] div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      cov_q     <= cov_d;
      longlow_q <= longlow_d;
      div_q     <= div_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.coverage_class   = cov_q;
  assign out_o.long_low_run     = longlow_q;
  assign out_o.divergence_class = div_q;

endmodule
